/* hw/rtl/ftov_pkg.sv */
`default_nettype none

package ftov_pkg;

  localparam int NUM_FRAMES_DEF = 64;

  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_INSTALL = 3'd1;
  localparam logic [2:0] KIND_FREE    = 3'd2;
  localparam logic [2:0] KIND_FIND    = 3'd3;
  localparam logic [2:0] KIND_PIN     = 3'd4;
  localparam logic [2:0] KIND_UNPIN   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_NOVICTIM = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  frame_slot;
    logic [7:0]  owner_id;
    logic [19:0] user_page;
    logic [31:0] now_tick;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  result_slot;
    logic        evicted;
    logic [7:0]  evicted_owner;
    logic [19:0] evicted_page;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        pinned;
    logic [7:0]  owner;
    logic [19:0] page;
    logic [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/frame_table_oldest_victim.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data   (ftov_pkg::req_t)
// out      output     out_valid / out_ready out_data  (ftov_pkg::rsp_t)
//
// Allocate, find and unpin read the whole table through the single read port of the
// entry memory, one entry per cycle. Install, free and pin read one entry and write
// it back if the slot is in range and holds a valid entry. After reset a clearing
// pass writes every entry to zero before the first transaction is accepted.
// A result waiting in the output register does not block the next transaction from
// being accepted; only its completion waits for the output register to drain.
`default_nettype none

module frame_table_oldest_victim #(
  parameter int NUM_FRAMES = ftov_pkg::NUM_FRAMES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire ftov_pkg::req_t in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      ftov_pkg::rsp_t out_data
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_FRAMES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_CHECK = 6'b001000,
    S_APPLY = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  ftov_pkg::req_t   req_r, req_nxt;
  logic             in_range_r, in_range_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             vic_r, vic_nxt;
  logic [IDX_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [31:0]      best_age_r, best_age_nxt;
  logic [7:0]       vic_owner_r, vic_owner_nxt;
  logic [19:0]      vic_page_r, vic_page_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  ftov_pkg::rsp_t   res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  ftov_pkg::rsp_t   out_data_r, out_data_nxt;

  ftov_pkg::entry_t mem [NUM_FRAMES];
  ftov_pkg::entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ftov_pkg::entry_t wr_data;

  ftov_pkg::entry_t e;
  logic [31:0]      age;
  logic             owner_eq;
  logic             in_range_in;
  logic [IDX_W-1:0] slot_in;
  logic             in_fire;
  logic             chk_ok;

  assign e           = rd_data_r;
  assign age         = req_r.now_tick - e.stamp;
  assign owner_eq    = (e.owner == req_r.owner_id);
  assign in_range_in = (32'(in_data.frame_slot) < 32'(NUM_FRAMES));
  assign slot_in     = IDX_W'(in_data.frame_slot);
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign chk_ok      = in_range_r && e.valid;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    in_range_nxt   = in_range_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    vic_nxt        = vic_r;
    vic_idx_nxt    = vic_idx_r;
    best_age_nxt   = best_age_r;
    vic_owner_nxt  = vic_owner_r;
    vic_page_nxt   = vic_page_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = e;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data;
          in_range_nxt   = in_range_in;
          slot_nxt       = slot_in;
          free_found_nxt = 1'b0;
          vic_nxt        = 1'b0;
          hit_nxt        = 1'b0;
          idx_nxt        = '0;
          rd_addr        = '0;
          res_nxt        = '0;
          unique case (in_data.kind) inside
            ftov_pkg::KIND_ALLOC, ftov_pkg::KIND_FIND, ftov_pkg::KIND_UNPIN: begin
              state_nxt = S_SCAN;
            end
            ftov_pkg::KIND_INSTALL, ftov_pkg::KIND_FREE, ftov_pkg::KIND_PIN: begin
              if (in_range_in) begin
                rd_addr = slot_in;
              end
              state_nxt = S_CHECK;
            end
            default: begin
              res_nxt.status = ftov_pkg::ST_MISS;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = (idx_r == LAST) ? idx_r : idx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        unique case (req_r.kind)
          ftov_pkg::KIND_ALLOC: begin
            if (!e.valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = idx_r;
            end
            if (e.valid && !e.pinned && (!vic_r || age > best_age_r)) begin
              vic_nxt       = 1'b1;
              vic_idx_nxt   = idx_r;
              best_age_nxt  = age;
              vic_owner_nxt = e.owner;
              vic_page_nxt  = e.page;
            end
          end
          ftov_pkg::KIND_FIND: begin
            if (!hit_r && e.valid && owner_eq && e.page == req_r.user_page) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = idx_r;
            end
          end
          ftov_pkg::KIND_UNPIN: begin
            wr_en          = e.valid && owner_eq;
            wr_data.pinned = 1'b0;
          end
          default: begin
          end
        endcase
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_APPLY;
        end
      end
      S_CHECK: begin
        wr_addr = slot_r;
        wr_en   = chk_ok;
        unique case (req_r.kind)
          ftov_pkg::KIND_INSTALL: begin
            wr_data.page = req_r.user_page;
          end
          ftov_pkg::KIND_FREE: begin
            wr_data.valid  = 1'b0;
            wr_data.pinned = 1'b0;
          end
          ftov_pkg::KIND_PIN: begin
            wr_data.pinned = 1'b1;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        res_nxt        = '0;
        res_nxt.status = chk_ok ? ftov_pkg::ST_OK : ftov_pkg::ST_MISS;
        state_nxt      = S_RESP;
      end
      S_APPLY: begin
        res_nxt       = '0;
        wr_data       = '0;
        wr_data.valid = 1'b1;
        wr_data.owner = req_r.owner_id;
        wr_data.stamp = req_r.now_tick;
        unique case (req_r.kind)
          ftov_pkg::KIND_ALLOC: begin
            if (free_found_r) begin
              wr_en               = 1'b1;
              wr_addr             = free_idx_r;
              res_nxt.status      = ftov_pkg::ST_OK;
              res_nxt.result_slot = 6'(free_idx_r);
            end else if (vic_r) begin
              wr_en                 = 1'b1;
              wr_addr               = vic_idx_r;
              res_nxt.status        = ftov_pkg::ST_OK;
              res_nxt.result_slot   = 6'(vic_idx_r);
              res_nxt.evicted       = 1'b1;
              res_nxt.evicted_owner = vic_owner_r;
              res_nxt.evicted_page  = vic_page_r;
            end else begin
              res_nxt.status = ftov_pkg::ST_NOVICTIM;
            end
          end
          ftov_pkg::KIND_FIND: begin
            if (hit_r) begin
              res_nxt.status      = ftov_pkg::ST_OK;
              res_nxt.result_slot = 6'(hit_idx_r);
            end else begin
              res_nxt.status = ftov_pkg::ST_MISS;
            end
          end
          ftov_pkg::KIND_UNPIN: begin
            res_nxt.status = ftov_pkg::ST_OK;
          end
          default: begin
            res_nxt.status = ftov_pkg::ST_MISS;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    in_range_r   <= in_range_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    vic_r        <= vic_nxt;
    vic_idx_r    <= vic_idx_nxt;
    best_age_r   <= best_age_nxt;
    vic_owner_r  <= vic_owner_nxt;
    vic_page_r   <= vic_page_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // The table is never written while the block waits for a transaction.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("table written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start");

  a_resp_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not delivered to an empty output register");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_CLEAR) |-> (idx_r <= LAST))
    else $error("scan index beyond table");

endmodule

`default_nettype wire

/* test/tb_frame_table_oldest_victim.sv */
`timescale 1ns / 1ps

module tb_frame_table_oldest_victim;

  localparam int FRAMES = ftov_pkg::NUM_FRAMES_DEF;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;
  localparam int TARGET_ITEMS = 1150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = FRAMES + 16;
  localparam int MAX_PRINTED = 40;

  class frame_table_checker;
    bit             slot_used [FRAMES];
    bit             slot_pin  [FRAMES];
    bit [7:0]       slot_owner[FRAMES];
    bit [19:0]      slot_page [FRAMES];
    bit [31:0]      slot_stamp[FRAMES];
    ftov_pkg::rsp_t pending_answers[$];
    int             mismatches;
    int             answers_seen;
    int             kind_count[8];
    int             eviction_count;
    int             no_victim_count;
    int             find_hit_count;

    function int free_slot_count();
      int n;
      n = 0;
      for (int i = 0; i < FRAMES; i++) begin
        if (!slot_used[i]) n++;
      end
      return n;
    endfunction

    function int random_live_slot();
      int start;
      int idx;
      start = $urandom_range(0, FRAMES - 1);
      for (int k = 0; k < FRAMES; k++) begin
        idx = (start + k) % FRAMES;
        if (slot_used[idx]) return idx;
      end
      return -1;
    endfunction

    function ftov_pkg::rsp_t predict_answer(ftov_pkg::req_t r);
      ftov_pkg::rsp_t a;
      int             pick;
      bit             have;
      bit             slot_ok;
      bit [31:0]      age;
      bit [31:0]      best;
      a = '0;
      a.status = ftov_pkg::ST_MISS;
      pick = -1;
      have = 1'b0;
      best = '0;
      slot_ok = (int'(r.frame_slot) < FRAMES) && slot_used[r.frame_slot];
      case (r.kind)
        ftov_pkg::KIND_ALLOC: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (!slot_used[i] && pick < 0) pick = i;
          end
          if (pick < 0) begin
            for (int i = 0; i < FRAMES; i++) begin
              if (!slot_pin[i]) begin
                age = r.now_tick - slot_stamp[i];
                if (!have || age > best) begin
                  have = 1'b1;
                  pick = i;
                  best = age;
                end
              end
            end
            if (have) begin
              a.evicted = 1'b1;
              a.evicted_owner = slot_owner[pick];
              a.evicted_page = slot_page[pick];
              eviction_count++;
            end
          end
          if (pick < 0) begin
            a.status = ftov_pkg::ST_NOVICTIM;
            no_victim_count++;
          end else begin
            slot_used[pick] = 1'b1;
            slot_pin[pick] = 1'b0;
            slot_owner[pick] = r.owner_id;
            slot_page[pick] = '0;
            slot_stamp[pick] = r.now_tick;
            a.status = ftov_pkg::ST_OK;
            a.result_slot = 6'(pick);
          end
        end
        ftov_pkg::KIND_INSTALL: begin
          if (slot_ok) begin
            slot_page[r.frame_slot] = r.user_page;
            a.status = ftov_pkg::ST_OK;
          end
        end
        ftov_pkg::KIND_FREE: begin
          if (slot_ok) begin
            slot_used[r.frame_slot] = 1'b0;
            slot_pin[r.frame_slot] = 1'b0;
            a.status = ftov_pkg::ST_OK;
          end
        end
        ftov_pkg::KIND_FIND: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (pick < 0 && slot_used[i] && slot_owner[i] == r.owner_id &&
                slot_page[i] == r.user_page) begin
              pick = i;
            end
          end
          if (pick >= 0) begin
            a.status = ftov_pkg::ST_OK;
            a.result_slot = 6'(pick);
            find_hit_count++;
          end
        end
        ftov_pkg::KIND_PIN: begin
          if (slot_ok) begin
            slot_pin[r.frame_slot] = 1'b1;
            a.status = ftov_pkg::ST_OK;
          end
        end
        ftov_pkg::KIND_UNPIN: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (slot_used[i] && slot_owner[i] == r.owner_id) slot_pin[i] = 1'b0;
          end
          a.status = ftov_pkg::ST_OK;
        end
        default: begin
          a.status = ftov_pkg::ST_MISS;
        end
      endcase
      return a;
    endfunction

    function void note_request(ftov_pkg::req_t r);
      kind_count[r.kind]++;
      pending_answers.push_back(predict_answer(r));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("%0t: result %0d: %s is %0h, expected %0h",
                 $time, answers_seen, what, got, want);
      end
    endtask

    task check_response(ftov_pkg::rsp_t got);
      ftov_pkg::rsp_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report("result with no request outstanding", 64'(got), 64'd0);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.result_slot !== want.result_slot)
          report("result_slot", 64'(got.result_slot), 64'(want.result_slot));
        if (got.evicted !== want.evicted)
          report("evicted", 64'(got.evicted), 64'(want.evicted));
        if (got.evicted_owner !== want.evicted_owner)
          report("evicted_owner", 64'(got.evicted_owner), 64'(want.evicted_owner));
        if (got.evicted_page !== want.evicted_page)
          report("evicted_page", 64'(got.evicted_page), 64'(want.evicted_page));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ftov_pkg::req_t in_data;
  logic out_valid;
  logic out_ready;
  ftov_pkg::rsp_t out_data;

  frame_table_checker table_chk = new();
  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  logic [31:0] tick_now;
  logic [7:0]  owner_pool[8];
  logic [19:0] page_pool[4];

  frame_table_oldest_victim u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic send(ftov_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 99) < 3) quiet_in = !quiet_in;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    table_chk.note_request(r);
    items_sent++;
  endtask

  function automatic ftov_pkg::req_t make_req(logic [2:0] k, logic [5:0] s, logic [7:0] o,
                                              logic [19:0] p, logic [31:0] t);
    ftov_pkg::req_t r;
    r.kind = k;
    r.frame_slot = s;
    r.owner_id = o;
    r.user_page = p;
    r.now_tick = t;
    return r;
  endfunction

  function automatic ftov_pkg::req_t noise_req();
    return make_req(3'($urandom_range(0, 7)), 6'($urandom), 8'($urandom),
                    20'($urandom), 32'($urandom));
  endfunction

  function logic [31:0] next_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) tick_now = tick_now + 32'($urandom_range(0, 3));
    else if (r < 95) tick_now = tick_now + 32'($urandom_range(0, 1000000));
    else tick_now = 32'($urandom);
    return tick_now;
  endfunction

  function automatic logic [7:0] pick_owner();
    if ($urandom_range(0, 4) != 0) return owner_pool[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic logic [19:0] pick_page();
    if ($urandom_range(0, 1) != 0) return page_pool[$urandom_range(0, 3)];
    return 20'($urandom);
  endfunction

  function automatic logic [5:0] target_slot();
    int s;
    s = table_chk.random_live_slot();
    if (s >= 0 && $urandom_range(0, 99) < 85) return 6'(s);
    return 6'($urandom);
  endfunction

  function automatic ftov_pkg::req_t alloc_req();
    ftov_pkg::req_t r;
    r = noise_req();
    r.kind = ftov_pkg::KIND_ALLOC;
    r.owner_id = pick_owner();
    r.now_tick = next_tick();
    return r;
  endfunction

  function automatic ftov_pkg::req_t random_request();
    ftov_pkg::req_t r;
    int             sel;
    int             s;
    r = noise_req();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      r = alloc_req();
    end else if (sel < 48) begin
      r.kind = ftov_pkg::KIND_INSTALL;
      r.frame_slot = target_slot();
      r.user_page = pick_page();
    end else if (sel < 58) begin
      r.kind = ftov_pkg::KIND_FREE;
      r.frame_slot = target_slot();
    end else if (sel < 73) begin
      r.kind = ftov_pkg::KIND_FIND;
      s = table_chk.random_live_slot();
      if (s >= 0 && $urandom_range(0, 9) < 6) begin
        r.owner_id = table_chk.slot_owner[s];
        r.user_page = table_chk.slot_page[s];
      end else begin
        r.owner_id = pick_owner();
        r.user_page = pick_page();
      end
    end else if (sel < 83) begin
      r.kind = ftov_pkg::KIND_PIN;
      r.frame_slot = target_slot();
    end else if (sel < 90) begin
      r.kind = ftov_pkg::KIND_UNPIN;
      r.owner_id = pick_owner();
    end else if (sel < 95) begin
      r.kind = ($urandom_range(0, 1) != 0) ? KIND_RSVD6 : KIND_RSVD7;
    end
    return r;
  endfunction

  task automatic fill_table();
    while (table_chk.free_slot_count() > 0) send(alloc_req());
  endtask

  task automatic pin_everything();
    ftov_pkg::req_t r;
    fill_table();
    for (int i = 0; i < FRAMES; i++) begin
      if (table_chk.slot_used[i] && !table_chk.slot_pin[i]) begin
        r = noise_req();
        r.kind = ftov_pkg::KIND_PIN;
        r.frame_slot = 6'(i);
        send(r);
      end
    end
    repeat (2) send(alloc_req());
    for (int j = 0; j < 8; j++) begin
      if ($urandom_range(0, 1) != 0) begin
        r = noise_req();
        r.kind = ftov_pkg::KIND_UNPIN;
        r.owner_id = owner_pool[j];
        send(r);
      end
    end
  endtask

  task automatic directed_checks();
    send(make_req(ftov_pkg::KIND_INSTALL, 6'd0, 8'd0, 20'd1, 32'd0));
    send(make_req(ftov_pkg::KIND_FREE, 6'd63, 8'hFF, 20'hFFFFF, 32'hFFFF_FFFF));
    send(make_req(ftov_pkg::KIND_PIN, 6'd5, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_FIND, 6'd0, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_UNPIN, 6'd0, 8'd0, 20'd0, 32'd0));
    send(make_req(KIND_RSVD6, 6'd1, 8'd1, 20'd1, 32'd1));
    send(make_req(KIND_RSVD7, 6'd63, 8'hFF, 20'hFFFFF, 32'hFFFF_FFFF));
    send(make_req(ftov_pkg::KIND_ALLOC, 6'd63, 8'd0, 20'hFFFFF, 32'd0));
    send(make_req(ftov_pkg::KIND_ALLOC, 6'd0, 8'hFF, 20'd0, 32'hFFFF_FFFF));
    send(make_req(ftov_pkg::KIND_ALLOC, 6'd0, 8'hFF, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_FIND, 6'd0, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_INSTALL, 6'd1, 8'd0, 20'hFFFFF, 32'd0));
    send(make_req(ftov_pkg::KIND_FIND, 6'd0, 8'hFF, 20'hFFFFF, 32'd0));
    send(make_req(ftov_pkg::KIND_FIND, 6'd0, 8'hFF, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_PIN, 6'd0, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_INSTALL, 6'd63, 8'd0, 20'd5, 32'd0));
    send(make_req(ftov_pkg::KIND_FREE, 6'd0, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_ALLOC, 6'd0, 8'h07, 20'd0, 32'h8000_0000));
    send(make_req(ftov_pkg::KIND_PIN, 6'd1, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_PIN, 6'd2, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_UNPIN, 6'd0, 8'hFF, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_FREE, 6'd1, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_FREE, 6'd1, 8'd0, 20'd0, 32'd0));
    send(make_req(ftov_pkg::KIND_ALLOC, 6'd0, 8'h5A, 20'd0, 32'h0000_0010));
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 499) == 0) quiet_out = !quiet_out;
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 19) == 0) stall = $urandom_range(20, 150);
        else stall = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1) table_chk.check_response(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int sel;
    in_valid <= 1'b0;
    in_data <= '0;
    rst_n <= 1'b0;
    tick_now = 32'hFFFF_FF00;
    owner_pool[0] = 8'h00;
    owner_pool[1] = 8'hFF;
    for (int j = 2; j < 8; j++) owner_pool[j] = 8'($urandom);
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    page_pool[2] = 20'h00001;
    page_pool[3] = 20'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed_checks();
    while (items_sent < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) fill_table();
      else if (sel < 12) pin_everything();
      else repeat ($urandom_range(10, 40)) send(random_request());
    end
    in_valid <= 1'b0;

    while (table_chk.pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $write("Sent %0d requests: %0d allocate, %0d install, %0d free, ",
           items_sent, table_chk.kind_count[ftov_pkg::KIND_ALLOC],
           table_chk.kind_count[ftov_pkg::KIND_INSTALL],
           table_chk.kind_count[ftov_pkg::KIND_FREE]);
    $display("%0d find, %0d pin, %0d unpin, %0d unused kind.",
             table_chk.kind_count[ftov_pkg::KIND_FIND],
             table_chk.kind_count[ftov_pkg::KIND_PIN],
             table_chk.kind_count[ftov_pkg::KIND_UNPIN],
             table_chk.kind_count[KIND_RSVD6] + table_chk.kind_count[KIND_RSVD7]);
    $display("Saw %0d evictions, %0d fully pinned allocations and %0d find hits; %0d errors.",
             table_chk.eviction_count, table_chk.no_victim_count, table_chk.find_hit_count,
             table_chk.mismatches);
    if (table_chk.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* frame_table_oldest_victim.f */
hw/rtl/ftov_pkg.sv
hw/rtl/frame_table_oldest_victim.sv
test/tb_frame_table_oldest_victim.sv
